[rtl/rau_pkg.sv]
// Shared types, opcodes and helpers for the rational arithmetic unit.
package rau_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 4;

    typedef enum logic [OpW-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_NE  = 4'd5,
        OP_LT  = 4'd6,
        OP_LE  = 4'd7,
        OP_GT  = 4'd8,
        OP_GE  = 4'd9
    } opcode_t;

    typedef struct packed {
        logic             start;
        logic [WordW-1:0] dividend;
        logic [WordW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WordW-1:0] quot;
        logic [WordW-1:0] rem;
    } div_rsp_t;

    function automatic logic [WordW-1:0] mag(input logic [WordW-1:0] x);
        mag = x[WordW-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

[rtl/rau_divider.sv]
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);

    import rau_pkg::*;

    localparam int unsigned CntW = $clog2(WordW + 1);

    logic [WordW-1:0] quot_reg, quot_next;
    logic [WordW-1:0] rem_reg, rem_next;
    logic [WordW-1:0] dsr_reg, dsr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WordW:0]   trial;
    logic [WordW:0]   shifted;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quot_reg[WordW-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CntW'(WordW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[WordW])
            begin
                rem_next  = shifted[WordW-1:0];
                quot_next = {quot_reg[WordW-2:0], 1'b0};
            end
            else
            begin
                rem_next  = trial[WordW-1:0];
                quot_next = {quot_reg[WordW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit: sequencer around a shared divider and multiplier.
//
//  channel | direction | handshake            | tdata fields, lowest bit first
//  s_axis  | in        | s_axis_tvalid/tready | opcode, a_num, a_den, b_num, b_den
//  m_axis  | out       | m_axis_tvalid/tready | res_num, res_den, cmp_true, div_zero_err
//
// One transaction in flight; s_axis_tready is low from acceptance until m_axis is taken.
// The divider produces one quotient bit a cycle, and each gcd step runs one divider pass.
// Zero denominators, eq, ne and unknown opcodes go from ST_DISPATCH straight to ST_OUT;
// add, sub and div run two gcd chains of up to 46 steps.
// rst_n clears the sequencer asynchronously; a stalled m_axis holds the result in place.
module rational_arith_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,  // opcode[3:0], a_num, a_den, b_num, b_den
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata   // res_num[30:0], res_den, cmp_true, div_zero_err
);

    import rau_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_GCD, ST_GCD_STEP,
        ST_DIV_GO, ST_DIV_WAIT,
        ST_S_L, ST_S_LM, ST_S_QA, ST_S_XQ, ST_S_XM, ST_S_YQ, ST_S_YM, ST_S_END,
        ST_N_PREP, ST_N_QN, ST_N_QD, ST_N_END,
        ST_P_MN, ST_P_MD, ST_FIN, ST_OUT
    } state_t;

    state_t           state_reg;
    state_t           div_ret_reg, gcd_ret_reg, norm_ret_reg;
    opcode_t          op_reg;
    logic [WordW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [WordW-1:0] ma_reg, mb_reg;
    logic [WordW-1:0] ga_reg, gb_reg;
    logic [WordW-1:0] l_reg, q_reg, x_reg, y_reg;
    logic [WordW-1:0] nn_reg, nd_reg;
    logic [WordW-1:0] dvd_reg, dvs_reg;
    logic [30:0]      res_num_reg;
    logic [WordW-1:0] res_den_reg;
    logic             cmp_reg, err_reg;

    div_req_t         dreq;
    div_rsp_t         drsp;

    logic [WordW-1:0] s_an, s_ad, s_bn, s_bd;
    logic [OpW-1:0]   s_op;
    logic [WordW-1:0] sum, diff, quot_neg;
    logic [WordW-1:0] mul_a, mul_b, prod;
    logic [WordW-1:0] norm_n, norm_d;
    logic             x_lt_y, y_lt_x;

    assign s_op = s_axis_tdata[3:0];
    assign s_an = s_axis_tdata[35:4];
    assign s_ad = s_axis_tdata[67:36];
    assign s_bn = s_axis_tdata[99:68];
    assign s_bd = s_axis_tdata[131:100];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {7'b0, err_reg, cmp_reg, res_den_reg, res_num_reg};

    assign sum      = x_reg + y_reg;
    assign diff     = x_reg - y_reg;
    assign quot_neg = ~drsp.quot + 1'b1;
    assign x_lt_y   = $signed(x_reg) < $signed(y_reg);
    assign y_lt_x   = $signed(y_reg) < $signed(x_reg);
    assign norm_n   = nn_reg[WordW-1] ? '0 : nn_reg;
    assign norm_d   = (nd_reg == '0) ? WordW'(1) : nd_reg;

    assign dreq.start    = (state_reg == ST_DIV_GO);
    assign dreq.dividend = dvd_reg;
    assign dreq.divisor  = dvs_reg;

    rau_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        case (state_reg)
            ST_S_LM:
            begin
                mul_a = drsp.quot;
                mul_b = mb_reg;
            end
            ST_S_XM:
            begin
                mul_a = q_reg;
                mul_b = an_reg;
            end
            ST_S_YM:
            begin
                mul_a = q_reg;
                mul_b = bn_reg;
            end
            ST_P_MN:
            begin
                mul_a = an_reg;
                mul_b = nn_reg;
            end
            ST_P_MD:
            begin
                mul_a = ad_reg;
                mul_b = nd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            div_ret_reg  <= ST_IDLE;
            gcd_ret_reg  <= ST_IDLE;
            norm_ret_reg <= ST_IDLE;
            op_reg       <= OP_ADD;
            an_reg       <= '0;
            ad_reg       <= '0;
            bn_reg       <= '0;
            bd_reg       <= '0;
            ma_reg       <= '0;
            mb_reg       <= '0;
            ga_reg       <= '0;
            gb_reg       <= '0;
            l_reg        <= '0;
            q_reg        <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            nn_reg       <= '0;
            nd_reg       <= '0;
            dvd_reg      <= '0;
            dvs_reg      <= '0;
            res_num_reg  <= '0;
            res_den_reg  <= '0;
            cmp_reg      <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg      <= opcode_t'(s_op);
                        an_reg      <= s_an;
                        ad_reg      <= s_ad;
                        bn_reg      <= s_bn;
                        bd_reg      <= s_bd;
                        ma_reg      <= mag(s_ad);
                        mb_reg      <= mag(s_bd);
                        res_num_reg <= '0;
                        res_den_reg <= WordW'(1);
                        cmp_reg     <= 1'b0;
                        err_reg     <= 1'b0;
                        state_reg   <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    if (ad_reg == '0 || bd_reg == '0)
                    begin
                        res_den_reg <= '0;
                        err_reg     <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_ADD, OP_SUB, OP_LT, OP_LE, OP_GT, OP_GE:
                            begin
                                ga_reg      <= ma_reg;
                                gb_reg      <= mb_reg;
                                gcd_ret_reg <= ST_S_L;
                                state_reg   <= ST_GCD;
                            end
                            OP_MUL:
                            begin
                                nn_reg    <= bn_reg;
                                nd_reg    <= bd_reg;
                                state_reg <= ST_P_MN;
                            end
                            OP_DIV:
                            begin
                                nn_reg       <= bd_reg;
                                nd_reg       <= bn_reg;
                                norm_ret_reg <= ST_P_MN;
                                state_reg    <= ST_N_PREP;
                            end
                            OP_EQ:
                            begin
                                cmp_reg   <= (an_reg == bn_reg) && (ad_reg == bd_reg);
                                state_reg <= ST_OUT;
                            end
                            OP_NE:
                            begin
                                cmp_reg   <= (an_reg != bn_reg) || (ad_reg != bd_reg);
                                state_reg <= ST_OUT;
                            end
                            default:
                                state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_GCD:
                begin
                    if (gb_reg == '0)
                        state_reg <= gcd_ret_reg;
                    else
                    begin
                        dvd_reg     <= ga_reg;
                        dvs_reg     <= gb_reg;
                        div_ret_reg <= ST_GCD_STEP;
                        state_reg   <= ST_DIV_GO;
                    end
                end
                ST_GCD_STEP:
                begin
                    ga_reg    <= gb_reg;
                    gb_reg    <= drsp.rem;
                    state_reg <= ST_GCD;
                end
                ST_DIV_GO:
                    state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT:
                begin
                    if (drsp.done)
                        state_reg <= div_ret_reg;
                end
                ST_S_L:
                begin
                    dvd_reg     <= ma_reg;
                    dvs_reg     <= ga_reg;
                    div_ret_reg <= ST_S_LM;
                    state_reg   <= ST_DIV_GO;
                end
                ST_S_LM:
                begin
                    l_reg     <= prod;
                    state_reg <= ST_S_QA;
                end
                ST_S_QA:
                begin
                    dvd_reg     <= mag(l_reg);
                    dvs_reg     <= ma_reg;
                    div_ret_reg <= ST_S_XQ;
                    state_reg   <= ST_DIV_GO;
                end
                ST_S_XQ:
                begin
                    q_reg     <= (l_reg[WordW-1] ^ ad_reg[WordW-1]) ? quot_neg : drsp.quot;
                    state_reg <= ST_S_XM;
                end
                ST_S_XM:
                begin
                    x_reg       <= prod;
                    dvd_reg     <= mag(l_reg);
                    dvs_reg     <= mb_reg;
                    div_ret_reg <= ST_S_YQ;
                    state_reg   <= ST_DIV_GO;
                end
                ST_S_YQ:
                begin
                    q_reg     <= (l_reg[WordW-1] ^ bd_reg[WordW-1]) ? quot_neg : drsp.quot;
                    state_reg <= ST_S_YM;
                end
                ST_S_YM:
                begin
                    y_reg     <= prod;
                    state_reg <= ST_S_END;
                end
                ST_S_END:
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            nn_reg       <= sum;
                            nd_reg       <= l_reg;
                            norm_ret_reg <= ST_FIN;
                            state_reg    <= ST_N_PREP;
                        end
                        OP_SUB:
                        begin
                            nn_reg       <= diff;
                            nd_reg       <= l_reg;
                            norm_ret_reg <= ST_FIN;
                            state_reg    <= ST_N_PREP;
                        end
                        OP_LT:
                        begin
                            cmp_reg   <= x_lt_y;
                            state_reg <= ST_OUT;
                        end
                        OP_LE:
                        begin
                            cmp_reg   <= !y_lt_x;
                            state_reg <= ST_OUT;
                        end
                        OP_GT:
                        begin
                            cmp_reg   <= y_lt_x;
                            state_reg <= ST_OUT;
                        end
                        OP_GE:
                        begin
                            cmp_reg   <= !x_lt_y;
                            state_reg <= ST_OUT;
                        end
                        default:
                            state_reg <= ST_OUT;
                    endcase
                end
                ST_N_PREP:
                begin
                    nn_reg <= norm_n;
                    nd_reg <= norm_d;
                    if (norm_n == '0)
                        state_reg <= norm_ret_reg;
                    else
                    begin
                        ga_reg      <= norm_n;
                        gb_reg      <= mag(norm_d);
                        gcd_ret_reg <= ST_N_QN;
                        state_reg   <= ST_GCD;
                    end
                end
                ST_N_QN:
                begin
                    dvd_reg     <= nn_reg;
                    dvs_reg     <= ga_reg;
                    div_ret_reg <= ST_N_QD;
                    state_reg   <= ST_DIV_GO;
                end
                ST_N_QD:
                begin
                    nn_reg      <= drsp.quot;
                    dvd_reg     <= mag(nd_reg);
                    dvs_reg     <= ga_reg;
                    div_ret_reg <= ST_N_END;
                    state_reg   <= ST_DIV_GO;
                end
                ST_N_END:
                begin
                    nd_reg    <= nd_reg[WordW-1] ? quot_neg : drsp.quot;
                    state_reg <= norm_ret_reg;
                end
                ST_P_MN:
                begin
                    nn_reg    <= prod;
                    state_reg <= ST_P_MD;
                end
                ST_P_MD:
                begin
                    nd_reg       <= prod;
                    norm_ret_reg <= ST_FIN;
                    state_reg    <= ST_N_PREP;
                end
                ST_FIN:
                begin
                    res_num_reg <= nn_reg[30:0];
                    res_den_reg <= nd_reg;
                    state_reg   <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid));

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && err_reg |-> res_num_reg == '0 && res_den_reg == '0 && !cmp_reg);

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !err_reg |-> res_den_reg != '0);

endmodule

[tb/rational_arith_unit_tb.sv]
// Testbench for the rational arithmetic unit: directed and random fractions against a predictor.
`timescale 1ns / 100ps

module rational_arith_unit_tb;
    import rau_pkg::*;

    localparam logic [3:0] OpUnusedLo = 4'd10;
    localparam logic [3:0] OpUnusedHi = 4'd15;

    typedef struct packed {
        logic [31:0] b_den;
        logic [31:0] b_num;
        logic [31:0] a_den;
        logic [31:0] a_num;
        logic [3:0]  opcode;
    } frac_op_t;

    typedef struct packed {
        logic        div_zero_err;
        logic        cmp_true;
        logic [31:0] res_den;
        logic [30:0] res_num;
    } frac_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    frac_op_t  pending_ops[$];
    frac_res_t expected_res[$];
    int        error_count;
    int        checked_count;
    bit        stim_done;
    bit        hold_rx;
    int        tx_gap;
    int        rx_gap;

    rational_arith_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] abs32(logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [31:0] quot32(logic [31:0] x, logic [31:0] y);
        logic [31:0] q;
        if (abs32(y) == 0)
            return 32'd0;
        q = abs32(x) / abs32(y);
        return ((x ^ y) & 32'h8000_0000) ? (32'd0 - q) : q;
    endfunction

    function automatic void reduce(logic [31:0] n, logic [31:0] d,
                                   output logic [31:0] on, output logic [31:0] od);
        logic [31:0] g;
        if (n[31])
            n = 0;
        if (d == 0)
            d = 1;
        g = gcd32(n, abs32(d));
        if (g == 0)
            g = 1;
        n = n / g;
        if (n != 0)
            d = quot32(d, g);
        on = n;
        od = d;
    endfunction

    function automatic logic [31:0] common_den(logic [31:0] ad, logic [31:0] bd);
        logic [31:0] g;
        g = gcd32(abs32(ad), abs32(bd));
        if (g == 0)
            g = 1;
        return (abs32(ad) / g) * abs32(bd);
    endfunction

    function automatic frac_res_t predict_fraction(frac_op_t op);
        frac_res_t   r;
        logic [31:0] l, x, y, rn, rd, qn, qd;
        r = '0;
        rn = 0;
        rd = 1;
        if (op.a_den == 0 || op.b_den == 0)
        begin
            r.div_zero_err = 1'b1;
            return r;
        end
        l = common_den(op.a_den, op.b_den);
        x = quot32(l, op.a_den) * op.a_num;
        y = quot32(l, op.b_den) * op.b_num;
        case (op.opcode)
            OP_ADD: reduce(x + y, l, rn, rd);
            OP_SUB: reduce(x - y, l, rn, rd);
            OP_MUL: reduce(op.a_num * op.b_num, op.a_den * op.b_den, rn, rd);
            OP_DIV:
            begin
                reduce(op.b_den, op.b_num, qn, qd);
                reduce(op.a_num * qn, op.a_den * qd, rn, rd);
            end
            OP_EQ: r.cmp_true = (op.a_num == op.b_num && op.a_den == op.b_den);
            OP_NE: r.cmp_true = (op.a_num != op.b_num || op.a_den != op.b_den);
            OP_LT: r.cmp_true = $signed(x) < $signed(y);
            OP_LE: r.cmp_true = $signed(x) <= $signed(y);
            OP_GT: r.cmp_true = $signed(x) > $signed(y);
            OP_GE: r.cmp_true = $signed(x) >= $signed(y);
            default: ;
        endcase
        r.res_num = rn[30:0];
        r.res_den = rd;
        return r;
    endfunction

    function automatic logic [31:0] rand_word(int shape);
        case (shape)
            0: return $urandom_range(1, 12);
            1: return 32'd0 - $urandom_range(1, 12);
            2: return $urandom_range(0, 1000);
            3: return 32'd0 - $urandom_range(0, 1000);
            4: return $urandom;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic frac_op_t rand_op();
        frac_op_t op;
        op.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OpUnusedLo, OpUnusedHi))
                                                 : 4'($urandom_range(0, 9));
        op.a_num = rand_word($urandom_range(0, 5));
        op.a_den = rand_word($urandom_range(0, 5));
        op.b_num = rand_word($urandom_range(0, 5));
        op.b_den = rand_word($urandom_range(0, 5));
        if ($urandom_range(0, 7) == 0)
        begin
            op.b_num = op.a_num;
            op.b_den = op.a_den;
        end
        if ($urandom_range(0, 30) == 0)
            op.a_den = 0;
        if ($urandom_range(0, 30) == 0)
            op.b_den = 0;
        return op;
    endfunction

    function automatic frac_op_t make_op(logic [3:0] code, logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [31:0] bd);
        frac_op_t op;
        op.opcode = code;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        return op;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap        <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                expected_res.push_back(predict_fraction(frac_op_t'(s_axis_tdata[131:0])));
            end
            if (tx_gap > 0 || pending_ops.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (tx_gap > 0)
                    tx_gap <= tx_gap - 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, pending_ops.pop_front()};
                tx_gap        <= pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                frac_res_t got, want;
                got = frac_res_t'(m_axis_tdata[64:0]);
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_res.pop_front();
                    checked_count <= checked_count + 1;
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected num %0d den %0d cmp %0b err %0b",
                                 $time, want.res_num, $signed(want.res_den),
                                 want.cmp_true, want.div_zero_err);
                        $display("%0t: mismatch actual   num %0d den %0d cmp %0b err %0b",
                                 $time, got.res_num, $signed(got.res_den),
                                 got.cmp_true, got.div_zero_err);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (hold_rx || rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                if (rx_gap > 0)
                    rx_gap <= rx_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap        <= pick_gap();
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        checked_count = 0;
        stim_done = 1'b0;
        hold_rx = 1'b0;
        pending_ops.push_back(make_op(OP_ADD, 1, 2, 1, 3));
        pending_ops.push_back(make_op(OP_SUB, 1, 3, 1, 2));
        pending_ops.push_back(make_op(OP_SUB, 3, 4, 1, 4));
        pending_ops.push_back(make_op(OP_MUL, 2, 3, 3, 4));
        pending_ops.push_back(make_op(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
        pending_ops.push_back(make_op(OP_DIV, 1, 2, 3, 4));
        pending_ops.push_back(make_op(OP_DIV, 5, 7, 0, 3));
        pending_ops.push_back(make_op(OP_DIV, 1, 1, 32'h8000_0000, 32'hffff_ffff));
        pending_ops.push_back(make_op(OP_EQ, 1, 2, 1, 2));
        pending_ops.push_back(make_op(OP_EQ, 1, 2, 2, 4));
        pending_ops.push_back(make_op(OP_NE, 1, 2, 2, 4));
        pending_ops.push_back(make_op(OP_NE, 3, 5, 3, 5));
        pending_ops.push_back(make_op(OP_LT, 1, 3, 1, 2));
        pending_ops.push_back(make_op(OP_LE, 2, 4, 1, 2));
        pending_ops.push_back(make_op(OP_GT, -1, 3, 1, -2));
        pending_ops.push_back(make_op(OP_GE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                      32'h8000_0000));
        pending_ops.push_back(make_op(OP_ADD, 0, 5, 0, 7));
        pending_ops.push_back(make_op(OP_ADD, 5, 0, 1, 2));
        pending_ops.push_back(make_op(OP_LT, 1, 2, 1, 0));
        pending_ops.push_back(make_op(OP_MUL, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                      32'hffff_ffff));
        pending_ops.push_back(make_op(OpUnusedHi, 3, 4, 5, 6));
        pending_ops.push_back(make_op(OpUnusedLo, 0, 1, 0, 1));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 500; i++)
            pending_ops.push_back(rand_op());
        wait (pending_ops.size() == 0 && !s_axis_tvalid && expected_res.size() == 0);
        hold_rx = 1'b1;
        for (int i = 0; i < 8; i++)
            pending_ops.push_back(rand_op());
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
        for (int i = 0; i < 1000; i++)
            pending_ops.push_back(rand_op());
        wait (pending_ops.size() == 0 && !s_axis_tvalid && expected_res.size() == 0);
        repeat (50) @(posedge clk);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        $display("Checked %0d results over all ten opcodes, unknown opcodes and zero denominators.",
                 checked_count);
        if (error_count == 0 && expected_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
